// ----- rtl/led_strip_fill_fade_animator_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the LED strip animator checks.
// Both macros sample on the rising edge of i_clk and are switched off while
// i_rst_n is low, so the scope that uses them must have both signals.
// ----------------------------------------------------------------------------
`ifndef LED_STRIP_FILL_FADE_ANIMATOR_DEFINES_SVH
`define LED_STRIP_FILL_FADE_ANIMATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LSFA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("animator check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define LSFA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("animator check failed in the next cycle");

`endif

// ----- rtl/lsfa_pkg.sv -----
// ----------------------------------------------------------------------------
// lsfa_pkg
// Shared widths, constants, codes and structs of the LED strip animator.
// ----------------------------------------------------------------------------
`default_nettype none

package lsfa_pkg;

    localparam int STRIP_LEDS = 90;

    localparam int ACTION_W = 4;
    localparam int TIME_W   = 32;
    localparam int FRAME_W  = 10;
    localparam int LEVEL_W  = 8;
    localparam int COUNT_W  = 7;
    localparam int FRAC_W   = 16;
    localparam int PROG_W   = 24;
    // Strip length times frame period, 90 * 1023 at most.
    localparam int LXF_W    = 17;

    localparam int DIV_N_W   = 40;
    localparam int DIV_D_W   = 32;
    localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);

    localparam logic [FRAME_W-1:0] FRAME_RESET = FRAME_W'(20);
    localparam logic [LEVEL_W-1:0] LEVEL_RESET = LEVEL_W'(200);
    localparam logic [PROG_W-1:0]  FULL_Q      = PROG_W'(STRIP_LEDS * (2 ** FRAC_W));
    // 0.1 in Q8.16.
    localparam logic [PROG_W-1:0]  MIN_STEP    = PROG_W'(6554);
    localparam logic [COUNT_W-1:0] STRIP_COUNT = COUNT_W'(STRIP_LEDS);

    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK      = 4'd0,
        ACT_FILL      = 4'd1,
        ACT_UNFILL    = 4'd2,
        ACT_FADE      = 4'd3,
        ACT_ON        = 4'd4,
        ACT_OFF       = 4'd5,
        ACT_BRIGHT    = 4'd6,
        ACT_PARTY_ON  = 4'd7,
        ACT_PARTY_OFF = 4'd8
    } t_action;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_FILL   = 2'd1,
        MODE_UNFILL = 2'd2,
        MODE_FADE   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_COMMIT
    } t_state;

    typedef struct packed {
        logic capture;
        logic div_start;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic need_div;
        logic div_done;
        logic out_free;
    } t_dp_stat;

    typedef struct packed {
        logic [COUNT_W-1:0] lit_count;
        logic [LEVEL_W-1:0] applied_brightness;
        logic               party_active;
        logic [1:0]         anim_mode;
        logic               anim_finished;
        logic               refresh;
        logic               ignored;
    } t_result;

endpackage

`default_nettype wire

// ----- rtl/lsfa_in_if.sv -----
// ----------------------------------------------------------------------------
// lsfa_in_if
// Command and frame tick channel: valid, ready and one input beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface lsfa_in_if;
    import lsfa_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [TIME_W-1:0]   payload;
    logic [TIME_W-1:0]   now_ms;

    modport source (output valid, action, payload, now_ms, input ready);
    modport sink   (input valid, action, payload, now_ms, output ready);
endinterface

`default_nettype wire

// ----- rtl/lsfa_out_if.sv -----
// ----------------------------------------------------------------------------
// lsfa_out_if
// Strip state channel: valid, ready and one result beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface lsfa_out_if;
    import lsfa_pkg::*;

    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] lit_count;
    logic [LEVEL_W-1:0] applied_brightness;
    logic               party_active;
    logic [1:0]         anim_mode;
    logic               anim_finished;
    logic               refresh;
    logic               ignored;

    modport source (
        output valid, lit_count, applied_brightness, party_active, anim_mode,
               anim_finished, refresh, ignored,
        input  ready
    );
    modport sink (
        input  valid, lit_count, applied_brightness, party_active, anim_mode,
               anim_finished, refresh, ignored,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/led_strip_fill_fade_animator.sv -----
// ----------------------------------------------------------------------------
// led_strip_fill_fade_animator
// Fill, unfill and fade animator for one warm-white LED strip.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one beat per command or frame tick: the action code, a
//   payload (speed or duration in ms, or the brightness in its low byte) and
//   the millisecond time stamp. Every beat gives exactly one beat on o_out:
//   the lit LED count, the applied brightness, the party flag, the animation
//   mode and the finished, refresh and ignored flags.
//   i_cfg_we with i_cfg_wdata writes the frame period in ms; write it only
//   while no beat is in flight.
// Sequence:
//   A beat that needs a division (fill or unfill with a nonzero speed, or a
//   fade tick before the end) goes through capture, preparation, the
//   bit-serial divider and the commit; all other beats skip the divider.
//   One beat is worked on at a time, so a new beat is accepted only once
//   the last one has been committed.
// Reset and stalls:
//   A synchronous low i_rst_n restores frame period 20 ms, idle mode, a dark
//   strip and brightness 200, and drops any result not yet taken.
//   The result waits in an output register, and a new beat is accepted while
//   it waits; a further result is held back until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module led_strip_fill_fade_animator (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    lsfa_in_if.sink                      i_in,
    lsfa_out_if.source                   o_out,
    input  logic                         i_cfg_we,
    input  logic [lsfa_pkg::FRAME_W-1:0] i_cfg_wdata
);
    import lsfa_pkg::*;

    // Commands from the sequencer and status back from the datapath.
    t_dp_cmd  cmd;
    t_dp_stat stat;
    logic     in_ready;
    logic     out_valid;
    t_result  result;

    // The sequencer owns the input handshake and steps each beat through
    // capture, operand preparation, the optional division and the commit.
    lsfa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // The datapath holds the animation state and the result register; the
    // commit is only issued when that register is free or being emptied.
    lsfa_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_action    (i_in.action),
        .i_payload   (i_in.payload),
        .i_now_ms    (i_in.now_ms),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_out_valid (out_valid),
        .i_out_ready (o_out.ready),
        .o_result    (result)
    );

    assign i_in.ready               = in_ready;
    assign o_out.valid              = out_valid;
    assign o_out.lit_count          = result.lit_count;
    assign o_out.applied_brightness = result.applied_brightness;
    assign o_out.party_active       = result.party_active;
    assign o_out.anim_mode          = result.anim_mode;
    assign o_out.anim_finished      = result.anim_finished;
    assign o_out.refresh            = result.refresh;
    assign o_out.ignored            = result.ignored;

endmodule

`default_nettype wire

// ----- rtl/lsfa_div.sv -----
// ----------------------------------------------------------------------------
// lsfa_div
// Restoring divider, one quotient bit per cycle, with a one-cycle done pulse.
// ----------------------------------------------------------------------------
`default_nettype none

module lsfa_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [lsfa_pkg::DIV_N_W-1:0] i_dividend,
    input  logic [lsfa_pkg::DIV_D_W-1:0] i_divisor,
    output logic                         o_done,
    output logic [lsfa_pkg::DIV_N_W-1:0] o_quotient
);
    import lsfa_pkg::*;

    localparam logic [DIV_CNT_W-1:0] CNT_LOAD = DIV_CNT_W'(DIV_N_W);
    localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(1);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_count;
    logic [DIV_N_W-1:0]   r_quo;
    logic [DIV_D_W-1:0]   r_rem;
    logic [DIV_D_W-1:0]   r_div;

    logic [DIV_D_W:0]     rem_sh;
    logic [DIV_D_W+1:0]   diff;
    logic                 fits;

    // The remainder stays below the divisor, so the shifted value needs one
    // extra bit and the trial subtraction one more for the borrow.
    always_comb begin
        rem_sh = {r_rem, r_quo[DIV_N_W-1]};
        diff   = {1'b0, rem_sh} - {2'b00, r_div};
        fits   = !diff[DIV_D_W+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_count <= CNT_LOAD;
            end else if (r_busy) begin
                r_count <= r_count - CNT_LAST;
                if (r_count == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIV_N_W-2:0], fits};
            r_rem <= fits ? diff[DIV_D_W-1:0] : rem_sh[DIV_D_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

// ----- rtl/lsfa_ctrl.sv -----
// ----------------------------------------------------------------------------
// lsfa_ctrl
// Sequencer: takes a beat, lets the datapath prepare, divide and commit.
// ----------------------------------------------------------------------------
`default_nettype none

module lsfa_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  lsfa_pkg::t_dp_stat i_stat,
    output lsfa_pkg::t_dp_cmd  o_cmd
);
    import lsfa_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_PREP;
            end
            ST_PREP: begin
                n_state = i_stat.need_div ? ST_DIV : ST_COMMIT;
            end
            ST_DIV: begin
                if (i_stat.div_done) n_state = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (i_stat.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready      = 1'b0;
        o_cmd.capture   = 1'b0;
        o_cmd.div_start = 1'b0;
        o_cmd.commit    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            ST_PREP: begin
                o_cmd.div_start = i_stat.need_div;
            end
            ST_DIV: begin
            end
            ST_COMMIT: begin
                o_cmd.commit = i_stat.out_free;
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/lsfa_datapath.sv -----
// ----------------------------------------------------------------------------
// lsfa_datapath
// Animation state, operand preparation, shared divider and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lsfa_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lsfa_pkg::t_dp_cmd             i_cmd,
    output lsfa_pkg::t_dp_stat            o_stat,
    input  logic [lsfa_pkg::ACTION_W-1:0] i_action,
    input  logic [lsfa_pkg::TIME_W-1:0]   i_payload,
    input  logic [lsfa_pkg::TIME_W-1:0]   i_now_ms,
    input  logic                          i_cfg_we,
    input  logic [lsfa_pkg::FRAME_W-1:0]  i_cfg_wdata,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output lsfa_pkg::t_result             o_result
);
    import lsfa_pkg::*;

    // Configuration and animation state.
    logic [FRAME_W-1:0] r_frame;
    t_mode              r_mode,       n_mode;
    logic [PROG_W-1:0]  r_progress,   n_progress;
    logic [PROG_W-1:0]  r_step,       n_step;
    logic [COUNT_W-1:0] r_shown,      n_shown;
    logic [TIME_W-1:0]  r_fade_begin, n_fade_begin;
    logic [TIME_W-1:0]  r_fade_len,   n_fade_len;
    logic [LEVEL_W-1:0] r_fade_lvl,   n_fade_lvl;
    logic [LEVEL_W-1:0] r_main,       n_main;
    logic [LEVEL_W-1:0] r_drive,      n_drive;
    logic               r_party,      n_party;

    // Captured beat.
    logic [ACTION_W-1:0] r_action;
    logic [TIME_W-1:0]   r_payload;
    logic [TIME_W-1:0]   r_now;
    logic [TIME_W-1:0]   r_elapsed;

    logic    r_out_valid;
    t_result r_result;
    t_result n_result;

    logic               is_anim_cmd;
    logic               fade_end;
    logic [TIME_W-1:0]  remaining;
    logic [LXF_W-1:0]   leds_x_frame;
    logic [DIV_N_W-1:0] dividend;
    logic [DIV_D_W-1:0] divisor;
    logic               div_done;
    logic [DIV_N_W-1:0] quotient;
    logic [PROG_W-1:0]  step_val;
    logic [PROG_W:0]    fill_sum;
    logic               finished;
    logic               refresh;
    logic               ignored;

    always_comb begin
        is_anim_cmd = (r_action == ACT_FILL) || (r_action == ACT_UNFILL) ||
                      (r_action == ACT_FADE) || (r_action == ACT_ON) ||
                      (r_action == ACT_OFF);
        fade_end     = r_elapsed >= r_fade_len;
        remaining    = r_fade_len - r_elapsed;
        leds_x_frame = LXF_W'(STRIP_LEDS) * LXF_W'(r_frame);
        if (r_action == ACT_TICK) begin
            dividend = DIV_N_W'(r_fade_lvl) * DIV_N_W'(remaining);
            divisor  = r_fade_len;
        end else begin
            dividend = {{(DIV_N_W - LXF_W - FRAC_W){1'b0}}, leds_x_frame, {FRAC_W{1'b0}}};
            divisor  = r_payload;
        end
    end

    always_comb begin
        o_stat.need_div = 1'b0;
        if (!(is_anim_cmd && r_party)) begin
            if ((r_action == ACT_FILL) || (r_action == ACT_UNFILL)) begin
                o_stat.need_div = r_payload != '0;
            end else if (r_action == ACT_TICK) begin
                o_stat.need_div = !r_party && (r_mode == MODE_FADE) && !fade_end;
            end
        end
        o_stat.div_done = div_done;
        o_stat.out_free = !r_out_valid || i_out_ready;
    end

    lsfa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (dividend),
        .i_divisor  (divisor),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    // Zero speed finishes in one frame; a step that rounds to zero is 0.1.
    always_comb begin
        if (r_payload == '0) begin
            step_val = FULL_Q;
        end else if (quotient > DIV_N_W'(FULL_Q)) begin
            step_val = FULL_Q;
        end else if (quotient == '0) begin
            step_val = MIN_STEP;
        end else begin
            step_val = quotient[PROG_W-1:0];
        end
    end

    always_comb begin
        n_mode       = r_mode;
        n_progress   = r_progress;
        n_step       = r_step;
        n_shown      = r_shown;
        n_fade_begin = r_fade_begin;
        n_fade_len   = r_fade_len;
        n_fade_lvl   = r_fade_lvl;
        n_main       = r_main;
        n_drive      = r_drive;
        n_party      = r_party;
        finished     = 1'b0;
        refresh      = 1'b0;
        ignored      = 1'b0;
        fill_sum     = {1'b0, r_progress} + {1'b0, r_step};

        if (is_anim_cmd && r_party) begin
            ignored = 1'b1;
        end else begin
            unique case (r_action)
                ACT_TICK: begin
                    if (!r_party && (r_mode != MODE_IDLE)) begin
                        refresh = 1'b1;
                        if (r_mode == MODE_FILL) begin
                            n_progress = (fill_sum > {1'b0, FULL_Q}) ? FULL_Q :
                                                                       fill_sum[PROG_W-1:0];
                            n_shown = n_progress[FRAC_W +: COUNT_W];
                            if (n_shown >= STRIP_COUNT) begin
                                finished = 1'b1;
                                n_mode   = MODE_IDLE;
                            end
                        end else if (r_mode == MODE_UNFILL) begin
                            n_progress = (r_progress > r_step) ? r_progress - r_step : '0;
                            n_shown    = n_progress[FRAC_W +: COUNT_W];
                            if (n_shown == '0) begin
                                finished = 1'b1;
                                n_mode   = MODE_IDLE;
                            end
                        end else if (fade_end) begin
                            n_drive  = '0;
                            n_main   = '0;
                            n_shown  = '0;
                            finished = 1'b1;
                            n_mode   = MODE_IDLE;
                        end else begin
                            n_drive = quotient[LEVEL_W-1:0];
                        end
                    end
                end
                ACT_FILL: begin
                    n_progress = '0;
                    n_step     = step_val;
                    n_drive    = r_main;
                    n_mode     = MODE_FILL;
                end
                ACT_UNFILL: begin
                    if (r_mode != MODE_FILL) n_progress = FULL_Q;
                    n_step = step_val;
                    n_mode = MODE_UNFILL;
                end
                ACT_FADE: begin
                    n_fade_begin = r_now;
                    n_fade_len   = (r_payload == '0) ? TIME_W'(1) : r_payload;
                    n_fade_lvl   = r_main;
                    n_mode       = MODE_FADE;
                end
                ACT_ON: begin
                    n_mode     = MODE_IDLE;
                    n_drive    = r_main;
                    n_shown    = STRIP_COUNT;
                    n_progress = FULL_Q;
                end
                ACT_OFF: begin
                    n_mode     = MODE_IDLE;
                    n_shown    = '0;
                    n_progress = '0;
                end
                ACT_BRIGHT: begin
                    n_main = r_payload[LEVEL_W-1:0];
                    if (!r_party) n_drive = r_payload[LEVEL_W-1:0];
                end
                ACT_PARTY_ON: begin
                    if (!r_party) begin
                        n_shown = '0;
                        n_party = 1'b1;
                        n_mode  = MODE_IDLE;
                    end
                end
                ACT_PARTY_OFF: begin
                    if (r_party) begin
                        n_party = 1'b0;
                        n_drive = r_main;
                        n_shown = '0;
                    end
                end
                default: begin
                end
            endcase
        end

        n_result.lit_count          = n_shown;
        n_result.applied_brightness = n_drive;
        n_result.party_active       = n_party;
        n_result.anim_mode          = n_mode;
        n_result.anim_finished      = finished;
        n_result.refresh            = refresh;
        n_result.ignored            = ignored;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame      <= FRAME_RESET;
            r_mode       <= MODE_IDLE;
            r_progress   <= '0;
            r_step       <= '0;
            r_shown      <= '0;
            r_fade_begin <= '0;
            r_fade_len   <= '0;
            r_fade_lvl   <= '0;
            r_main       <= LEVEL_RESET;
            r_drive      <= LEVEL_RESET;
            r_party      <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) r_frame <= i_cfg_wdata;
            if (i_cmd.commit) begin
                r_mode       <= n_mode;
                r_progress   <= n_progress;
                r_step       <= n_step;
                r_shown      <= n_shown;
                r_fade_begin <= n_fade_begin;
                r_fade_len   <= n_fade_len;
                r_fade_lvl   <= n_fade_lvl;
                r_main       <= n_main;
                r_drive      <= n_drive;
                r_party      <= n_party;
                r_out_valid  <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_action  <= i_action;
            r_payload <= i_payload;
            r_now     <= i_now_ms;
            r_elapsed <= i_now_ms - r_fade_begin;
        end
        if (i_cmd.commit) r_result <= n_result;
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

endmodule

`default_nettype wire

// ----- rtl/lsfa_checker.sv -----
// ----------------------------------------------------------------------------
// lsfa_checker
// Port-level checks of the animator's result beats, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "led_strip_fill_fade_animator_defines.svh"

module lsfa_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [lsfa_pkg::COUNT_W-1:0] i_lit_count,
    input logic [lsfa_pkg::LEVEL_W-1:0] i_applied_brightness,
    input logic                         i_party_active,
    input logic [1:0]                   i_anim_mode,
    input logic                         i_anim_finished,
    input logic                         i_refresh,
    input logic                         i_ignored
);
    import lsfa_pkg::*;

    // A finished animation leaves the block idle, and only a frame finishes.
    `LSFA_ASSERT_NOW(a_finish_idle, i_out_valid && i_anim_finished, (i_anim_mode == MODE_IDLE) && i_refresh)

    // A dropped command happens only in party mode and never runs a frame.
    `LSFA_ASSERT_NOW(a_ignored_party, i_out_valid && i_ignored, i_party_active && !i_refresh && !i_anim_finished)

    // In party mode no animation runs.
    `LSFA_ASSERT_NOW(a_party_still, i_out_valid && i_party_active, (i_anim_mode == MODE_IDLE) && !i_refresh)

    // The lit count never exceeds the strip.
    `LSFA_ASSERT_NOW(a_count_range, i_out_valid, i_lit_count <= STRIP_COUNT)

    // A stalled result beat stays put.
    `LSFA_ASSERT_NEXT(a_stall_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_lit_count) && $stable(i_applied_brightness) && $stable(i_anim_mode))

endmodule

bind led_strip_fill_fade_animator lsfa_checker u_lsfa_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .i_out_valid          (o_out.valid),
    .i_out_ready          (o_out.ready),
    .i_lit_count          (o_out.lit_count),
    .i_applied_brightness (o_out.applied_brightness),
    .i_party_active       (o_out.party_active),
    .i_anim_mode          (o_out.anim_mode),
    .i_anim_finished      (o_out.anim_finished),
    .i_refresh            (o_out.refresh),
    .i_ignored            (o_out.ignored)
);

`default_nettype wire
